### rtl/lrs_pkg.sv
// Shared types, constants and helper functions for the link rate selector.
package lrs_pkg;

    // Rate table geometry and field widths
    localparam int ENTRY_COUNT = 4;
    localparam int IDX_W       = 2;
    localparam int CNT_W       = 32;
    localparam int PCT_W       = 7;
    localparam int MCS_W       = 4;
    localparam int KBPS_W      = 18;
    localparam int SNR_W       = 8;
    localparam int WIN_W       = 16;
    localparam int PROD_W      = CNT_W + KBPS_W;

    // Port widths
    localparam int S_TDATA_W   = 48;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 96;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Scale for the error percent
    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

    // Register reset values
    localparam logic [PCT_W-1:0]        PER_LIMIT_RST = 7'd50;
    localparam logic signed [SNR_W-1:0] SNR_FLOOR_RST = 8'sd5;
    localparam logic signed [SNR_W-1:0] SNR_QAM64_RST = 8'sd25;
    localparam logic signed [SNR_W-1:0] SNR_QAM1K_RST = 8'sd32;
    localparam logic signed [SNR_W-1:0] SNR_QAM4K_RST = 8'sd38;
    localparam logic [WIN_W-1:0]        WINDOW_MS_RST = 16'd1000;

    // Command codes carried in s_tuser
    typedef enum logic [1:0] {
        CMD_TX_REPORT = 2'd0,
        CMD_RATE_REQ  = 2'd1,
        CMD_TICK      = 2'd2,
        CMD_NOP       = 2'd3
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PER_LIMIT = 3'd0,
        REG_SNR_FLOOR = 3'd1,
        REG_SNR_QAM64 = 3'd2,
        REG_SNR_QAM1K = 3'd3,
        REG_SNR_QAM4K = 3'd4,
        REG_WINDOW_MS = 3'd5
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_PCT_MUL,
        ST_PCT_GO,
        ST_PCT_WAIT,
        ST_TP_MUL,
        ST_TP_GO,
        ST_TP_WAIT,
        ST_SCAN,
        ST_SCAN_END,
        ST_MAINT,
        ST_EMIT
    } state_t;

    // Status from the shared divider
    typedef struct packed {
        logic done;
        logic sat;
    } div_stat_t;

    // MCS of each table entry
    function automatic logic [MCS_W-1:0] entry_mcs(input logic [IDX_W-1:0] idx);
        logic [MCS_W-1:0] mcs;
        case (idx)
            2'd0:    mcs = 4'd0;
            2'd1:    mcs = 4'd7;
            2'd2:    mcs = 4'd11;
            default: mcs = 4'd13;
        endcase
        return mcs;
    endfunction

    // Nominal PHY rate of each table entry in kbps
    function automatic logic [KBPS_W-1:0] entry_kbps(input logic [IDX_W-1:0] idx);
        logic [KBPS_W-1:0] kbps;
        case (idx)
            2'd0:    kbps = 18'd6000;
            2'd1:    kbps = 18'd65000;
            2'd2:    kbps = 18'd143400;
            default: kbps = 18'd172100;
        endcase
        return kbps;
    endfunction

    // Saturating increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + CNT_W'(1);
    endfunction

endpackage

### rtl/lrs_div.sv
// Shared restoring divider, one quotient bit per cycle, saturating at 32 bits.
module lrs_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [lrs_pkg::PROD_W-1:0]    dividend,
    input  logic [lrs_pkg::CNT_W-1:0]     divisor,
    output logic [lrs_pkg::CNT_W-1:0]     quotient,
    output lrs_pkg::div_stat_t            stat
);

    localparam int CW     = lrs_pkg::CNT_W;
    localparam int STEP_W = $clog2(CW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic              sat_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CW-1:0]     rem_reg;
    logic [CW-1:0]     quo_reg;
    logic [CW-1:0]     dvs_reg;

    logic [CW-1:0]     hi_part;
    logic [CW:0]       trial;
    logic [CW+1:0]     diff;
    logic              fits;

    // Upper dividend bits form the starting remainder
    assign hi_part = CW'(dividend[lrs_pkg::PROD_W-1:CW]);
    assign trial   = {rem_reg, quo_reg[CW-1]};
    assign diff    = {1'b0, trial} - {2'b00, dvs_reg};
    assign fits    = ~diff[CW+1];

    // Sequence the 32 steps; a quotient of 2^32 or more saturates at once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (hi_part >= divisor) begin
                    sat_reg  <= 1'b1;
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end else begin
                    sat_reg  <= 1'b0;
                    busy_reg <= 1'b1;
                    step_reg <= STEP_W'(CW);
                end
            end else if (busy_reg) begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift and subtract
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= hi_part;
            quo_reg <= dividend[CW-1:0];
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[CW-1:0] : trial[CW-1:0];
            quo_reg <= {quo_reg[CW-2:0], fits};
        end
    end

    assign quotient  = quo_reg;
    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;

endmodule

### rtl/link_rate_selector_top.sv
// Top level of the link rate selector: entry statistics, sequencer and result register.
// Usage:
//   The slave channel takes one command beat: s_tuser holds the command
//   (transmit report, rate request, maintenance tick, or no operation), and
//   s_tdata holds the success flag, the measured SNR and the time in ms.
//   Every command yields exactly one master beat that describes the current
//   rate entry after the command. Config goes over cfg_valid, cfg_index, cfg_data,
//   always ready; the user writes only while no command is in flight (not enforced).
// Timing:
//   A transmit report runs from acceptance to m_tvalid through two divisions
//   in turn on the shared divider, one quotient bit per cycle, each after a
//   multiply; a saturating throughput ends its division early. With no successes
//   or no elapsed time the second division is skipped. A rate request scans
//   every entry, a maintenance tick sweeps every entry and a no-op goes straight
//   to the result. s_tready is high only while the sequencer is idle, so the
//   next command is taken from the cycle m_tvalid rises.
// Reset:
//   aresetn low clears all statistics, the current entry (MCS 0), the switch
//   counter, and loads the register defaults.
// Stall:
//   A finished result waits in the output register; the next command is still
//   accepted, and its own result waits until the master side takes the first.
module link_rate_selector_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Command channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata from bit 0: success[0], snr_db[8:1], now_ms[40:9], zero pad
    input  logic [lrs_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser from bit 0: command[1:0]
    input  logic [lrs_pkg::S_TUSER_W-1:0]     s_tuser,
    // Result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata from bit 0: rate_index[1:0], mcs[5:2], nominal kbps[23:6],
    // error_percent[30:24], throughput_est[62:31], rate_switches[94:63], pad
    output logic [lrs_pkg::M_TDATA_W-1:0]     m_tdata,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lrs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lrs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int NE  = lrs_pkg::ENTRY_COUNT;
    localparam int IW  = lrs_pkg::IDX_W;
    localparam int CW  = lrs_pkg::CNT_W;
    localparam int PW  = lrs_pkg::PCT_W;
    localparam int SW  = lrs_pkg::SNR_W;
    localparam int LAST_IDX = NE - 1;

    // Configuration registers
    logic [PW-1:0]                    per_limit_reg;
    logic signed [SW-1:0]             snr_floor_reg;
    logic signed [SW-1:0]             snr_qam64_reg;
    logic signed [SW-1:0]             snr_qam1k_reg;
    logic signed [SW-1:0]             snr_qam4k_reg;
    logic [lrs_pkg::WIN_W-1:0]        window_ms_reg;

    // Entry statistics
    logic [CW-1:0] att_reg  [NE];
    logic [CW-1:0] suc_reg  [NE];
    logic [CW-1:0] fail_reg [NE];
    logic [PW-1:0] pct_reg  [NE];
    logic [CW-1:0] tp_reg   [NE];
    logic [CW-1:0] ws_reg   [NE];

    logic [IW-1:0] cur_reg;
    logic [CW-1:0] switch_cnt_reg;

    // Sequencer
    lrs_pkg::state_t state_reg, state_next;
    logic [IW-1:0]   idx_reg;
    logic [IW-1:0]   best_idx_reg;
    logic [CW-1:0]   best_tp_reg;

    // Latched command
    logic                  ok_reg;
    logic signed [SW-1:0]  snr_reg;
    logic [CW-1:0]         now_reg;

    // Shared multiply and divide
    logic [lrs_pkg::PROD_W-1:0] prod_reg;
    logic [CW-1:0]              mul_a;
    logic [lrs_pkg::KBPS_W-1:0] mul_b;
    logic [CW-1:0]              div_dvs;
    logic [CW-1:0]              div_quo;
    lrs_pkg::div_stat_t         div_stat;

    // Output register
    logic                          m_tvalid_reg;
    logic [lrs_pkg::M_TDATA_W-1:0] m_tdata_reg;

    // Control strobes
    logic load_item, upd_cnt, mul_en, div_start;
    logic pct_wr, tp_wr, scan_step, scan_end, maint_step, emit_load;

    // Entry read port
    logic [IW-1:0] rd_idx;
    logic [CW-1:0] att_rd, suc_rd, fail_rd, tp_rd, ws_rd;
    logic [PW-1:0] pct_rd;
    logic [CW-1:0] age;
    logic          snr_ok;
    logic          qualify;
    logic          out_free;
    lrs_pkg::cmd_t cmd_in;

    assign cmd_in   = lrs_pkg::cmd_t'(s_tuser);
    assign out_free = !m_tvalid_reg || m_tready;

    // Select the entry: scan index during sweeps, current entry otherwise
    assign rd_idx  = (state_reg == lrs_pkg::ST_SCAN || state_reg == lrs_pkg::ST_MAINT)
                     ? idx_reg : cur_reg;
    assign att_rd  = att_reg[rd_idx];
    assign suc_rd  = suc_reg[rd_idx];
    assign fail_rd = fail_reg[rd_idx];
    assign pct_rd  = pct_reg[rd_idx];
    assign tp_rd   = tp_reg[rd_idx];
    assign ws_rd   = ws_reg[rd_idx];
    assign age     = now_reg - ws_rd;

    // SNR thresholds per entry
    always_comb begin
        case (rd_idx)
            2'd1:    snr_ok = (snr_reg >= snr_qam64_reg);
            2'd2:    snr_ok = (snr_reg >= snr_qam1k_reg);
            2'd3:    snr_ok = (snr_reg >= snr_qam4k_reg);
            default: snr_ok = 1'b1;
        endcase
    end
    assign qualify = (pct_rd <= per_limit_reg) && (snr_reg >= snr_floor_reg) && snr_ok;

    // Operand selection for the shared multiplier and divider
    assign mul_a   = (state_reg == lrs_pkg::ST_PCT_MUL) ? fail_rd : suc_rd;
    assign mul_b   = (state_reg == lrs_pkg::ST_PCT_MUL)
                     ? lrs_pkg::KBPS_W'(lrs_pkg::PCT_SCALE) : lrs_pkg::entry_kbps(cur_reg);
    assign div_dvs = (state_reg == lrs_pkg::ST_PCT_GO) ? att_rd : age;

    lrs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (div_dvs),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lrs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (cmd_in)
                        lrs_pkg::CMD_TX_REPORT: state_next = lrs_pkg::ST_UPDATE;
                        lrs_pkg::CMD_RATE_REQ:  state_next = lrs_pkg::ST_SCAN;
                        lrs_pkg::CMD_TICK:      state_next = lrs_pkg::ST_MAINT;
                        default:                state_next = lrs_pkg::ST_EMIT;
                    endcase
                end
            end
            lrs_pkg::ST_UPDATE:  state_next = lrs_pkg::ST_PCT_MUL;
            lrs_pkg::ST_PCT_MUL: state_next = lrs_pkg::ST_PCT_GO;
            lrs_pkg::ST_PCT_GO:  state_next = lrs_pkg::ST_PCT_WAIT;
            lrs_pkg::ST_PCT_WAIT: begin
                if (div_stat.done) begin
                    state_next = (suc_rd != '0 && age != '0)
                                 ? lrs_pkg::ST_TP_MUL : lrs_pkg::ST_EMIT;
                end
            end
            lrs_pkg::ST_TP_MUL:  state_next = lrs_pkg::ST_TP_GO;
            lrs_pkg::ST_TP_GO:   state_next = lrs_pkg::ST_TP_WAIT;
            lrs_pkg::ST_TP_WAIT: begin
                if (div_stat.done) begin
                    state_next = lrs_pkg::ST_EMIT;
                end
            end
            lrs_pkg::ST_SCAN: begin
                if (idx_reg == IW'(LAST_IDX)) begin
                    state_next = lrs_pkg::ST_SCAN_END;
                end
            end
            lrs_pkg::ST_SCAN_END: state_next = lrs_pkg::ST_EMIT;
            lrs_pkg::ST_MAINT: begin
                if (idx_reg == IW'(LAST_IDX)) begin
                    state_next = lrs_pkg::ST_EMIT;
                end
            end
            lrs_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = lrs_pkg::ST_IDLE;
                end
            end
            default: state_next = lrs_pkg::ST_IDLE;
        endcase
    end

    // Control strobes per state
    always_comb begin
        s_tready   = 1'b0;
        load_item  = 1'b0;
        upd_cnt    = 1'b0;
        mul_en     = 1'b0;
        div_start  = 1'b0;
        pct_wr     = 1'b0;
        tp_wr      = 1'b0;
        scan_step  = 1'b0;
        scan_end   = 1'b0;
        maint_step = 1'b0;
        emit_load  = 1'b0;
        unique case (state_reg)
            lrs_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                load_item = s_tvalid;
            end
            lrs_pkg::ST_UPDATE:   upd_cnt    = 1'b1;
            lrs_pkg::ST_PCT_MUL:  mul_en     = 1'b1;
            lrs_pkg::ST_PCT_GO:   div_start  = 1'b1;
            lrs_pkg::ST_PCT_WAIT: pct_wr     = div_stat.done;
            lrs_pkg::ST_TP_MUL:   mul_en     = 1'b1;
            lrs_pkg::ST_TP_GO:    div_start  = 1'b1;
            lrs_pkg::ST_TP_WAIT:  tp_wr      = div_stat.done;
            lrs_pkg::ST_SCAN:     scan_step  = 1'b1;
            lrs_pkg::ST_SCAN_END: scan_end   = 1'b1;
            lrs_pkg::ST_MAINT:    maint_step = 1'b1;
            lrs_pkg::ST_EMIT:     emit_load  = out_free;
            default: ;
        endcase
    end

    // Advance the sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lrs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Write configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            per_limit_reg <= lrs_pkg::PER_LIMIT_RST;
            snr_floor_reg <= lrs_pkg::SNR_FLOOR_RST;
            snr_qam64_reg <= lrs_pkg::SNR_QAM64_RST;
            snr_qam1k_reg <= lrs_pkg::SNR_QAM1K_RST;
            snr_qam4k_reg <= lrs_pkg::SNR_QAM4K_RST;
            window_ms_reg <= lrs_pkg::WINDOW_MS_RST;
        end else if (cfg_valid) begin
            unique case (lrs_pkg::cfg_reg_t'(cfg_index))
                lrs_pkg::REG_PER_LIMIT: per_limit_reg <= cfg_data[PW-1:0];
                lrs_pkg::REG_SNR_FLOOR: snr_floor_reg <= cfg_data[SW-1:0];
                lrs_pkg::REG_SNR_QAM64: snr_qam64_reg <= cfg_data[SW-1:0];
                lrs_pkg::REG_SNR_QAM1K: snr_qam1k_reg <= cfg_data[SW-1:0];
                lrs_pkg::REG_SNR_QAM4K: snr_qam4k_reg <= cfg_data[SW-1:0];
                lrs_pkg::REG_WINDOW_MS: window_ms_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Latch the command beat and run the shared multiplier
    always_ff @(posedge aclk) begin
        if (load_item) begin
            ok_reg  <= s_tdata[0];
            snr_reg <= s_tdata[SW:1];
            now_reg <= s_tdata[SW+CW:SW+1];
        end
        if (mul_en) begin
            prod_reg <= lrs_pkg::PROD_W'(mul_a) * lrs_pkg::PROD_W'(mul_b);
        end
    end

    // Update entry statistics, scan and sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NE; i++) begin
                att_reg[i]  <= '0;
                suc_reg[i]  <= '0;
                fail_reg[i] <= '0;
                pct_reg[i]  <= '0;
                tp_reg[i]   <= '0;
                ws_reg[i]   <= '0;
            end
            cur_reg        <= '0;
            switch_cnt_reg <= '0;
            idx_reg        <= '0;
            best_idx_reg   <= '0;
            best_tp_reg    <= '0;
        end else begin
            if (load_item) begin
                idx_reg      <= '0;
                best_idx_reg <= cur_reg;
                best_tp_reg  <= '0;
            end
            // Count the attempt and its outcome
            if (upd_cnt) begin
                att_reg[cur_reg] <= lrs_pkg::sat_inc(att_rd);
                if (ok_reg) begin
                    suc_reg[cur_reg] <= lrs_pkg::sat_inc(suc_rd);
                end else begin
                    fail_reg[cur_reg] <= lrs_pkg::sat_inc(fail_rd);
                end
            end
            if (pct_wr) begin
                pct_reg[cur_reg] <= div_quo[PW-1:0];
            end
            if (tp_wr) begin
                tp_reg[cur_reg] <= div_stat.sat ? '1 : div_quo;
            end
            // Keep the best qualifying entry; ties keep the earlier one
            if (scan_step) begin
                if (qualify && tp_rd > best_tp_reg) begin
                    best_tp_reg  <= tp_rd;
                    best_idx_reg <= idx_reg;
                end
                idx_reg <= idx_reg + IW'(1);
            end
            if (scan_end && best_idx_reg != cur_reg) begin
                cur_reg        <= best_idx_reg;
                switch_cnt_reg <= lrs_pkg::sat_inc(switch_cnt_reg);
            end
            // Drop entries whose window has aged out
            if (maint_step) begin
                if (age > CW'(window_ms_reg)) begin
                    att_reg[idx_reg]  <= '0;
                    suc_reg[idx_reg]  <= '0;
                    fail_reg[idx_reg] <= '0;
                    pct_reg[idx_reg]  <= '0;
                    tp_reg[idx_reg]   <= '0;
                    ws_reg[idx_reg]   <= now_reg;
                end
                idx_reg <= idx_reg + IW'(1);
            end
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_load) begin
            m_tdata_reg <= {1'b0, switch_cnt_reg, tp_rd, pct_rd,
                            lrs_pkg::entry_kbps(cur_reg), lrs_pkg::entry_mcs(cur_reg),
                            cur_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Divider reports only while a division is awaited
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == lrs_pkg::ST_PCT_WAIT ||
                           state_reg == lrs_pkg::ST_TP_WAIT))
        else $error("divider finished outside a wait state");

    // Current entry moves only at the end of a rate scan
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(cur_reg) |-> $past(state_reg) == lrs_pkg::ST_SCAN_END)
        else $error("current entry changed outside a rate scan");

    // Switch counter never goes backward
    assert property (@(posedge aclk) disable iff (!aresetn)
        switch_cnt_reg >= $past(switch_cnt_reg))
        else $error("switch counter decreased");

    // Error percent shown is never above one hundred
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lrs_pkg::ST_EMIT |-> pct_rd <= lrs_pkg::PCT_SCALE)
        else $error("error percent out of range");

endmodule
